// ===== rtl/iepf_pkg.sv =====
// Shared types and constants of the ICMP echo parity packet filter.
// Depends on nothing; used by iepf_parse and icmp_echo_parity_packet_filter.
package iepf_pkg;

  localparam int unsigned OFF_W = 7;

  localparam logic [OFF_W-1:0] OFF_MAX = 7'd127;
  localparam logic [OFF_W-1:0] OFF_TYPE_HI = 7'd12;
  localparam logic [OFF_W-1:0] OFF_TYPE_LO = 7'd13;
  localparam logic [OFF_W-1:0] OFF_INNER_HI = 7'd16;
  localparam logic [OFF_W-1:0] OFF_INNER_LO = 7'd17;

  localparam logic [7:0] ETH_LEN = 8'd14;
  localparam logic [7:0] TAG_LEN = 8'd4;
  localparam logic [7:0] IPV4_LEN = 8'd20;
  localparam logic [7:0] IPV6_LEN = 8'd40;
  localparam logic [7:0] ICMP_LEN = 8'd8;

  localparam logic [OFF_W-1:0] IPV4_PROTO_AT = 7'd9;
  localparam logic [OFF_W-1:0] IPV6_PROTO_AT = 7'd6;

  localparam logic [15:0] TYPE_8021Q = 16'h8100;
  localparam logic [15:0] TYPE_8021AD = 16'h88A8;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  typedef enum logic [1:0] {
    L3_NONE = 2'd0,
    L3_IPV4 = 2'd1,
    L3_IPV6 = 2'd2
  } l3_kind_t;

  typedef enum logic {
    VERDICT_PASS = 1'b0,
    VERDICT_DROP = 1'b1
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } iepf_beat_t;

  function automatic l3_kind_t kind_of(input logic [15:0] etype);
    kind_of = (etype == TYPE_IPV6) ? L3_IPV6 : L3_IPV4;
  endfunction

endpackage

// ===== rtl/iepf_parse.sv =====
// Header parser of the ICMP echo parity packet filter: per-frame state and verdict logic.
// Depends on iepf_pkg.
module iepf_parse
  import iepf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  iepf_beat_t beat,
  output verdict_t   verdict
);

  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [15:0]      outer_ethertype, outer_ethertype_next;
  logic             vlan_tagged, vlan_tagged_next;
  l3_kind_t         l3_kind, l3_kind_next;
  logic [7:0]       next_protocol, next_protocol_next;
  logic             sequence_even, sequence_even_next;

  logic [OFF_W-1:0] base_now;
  logic [OFF_W-1:0] rel;
  logic [OFF_W-1:0] proto_at;
  logic [OFF_W-1:0] seq_at;
  logic [15:0]      etype_full;
  logic [7:0]       len;
  logic [7:0]       base;
  logic [7:0]       hdr_end;
  logic [7:0]       proto;

  always_comb begin
    outer_ethertype_next = outer_ethertype;
    vlan_tagged_next = vlan_tagged;
    l3_kind_next = l3_kind;
    next_protocol_next = next_protocol;
    sequence_even_next = sequence_even;
    base_now = vlan_tagged ? 7'(ETH_LEN + TAG_LEN) : 7'(ETH_LEN);
    rel = byte_offset - base_now;
    proto_at = (l3_kind == L3_IPV6) ? IPV6_PROTO_AT : IPV4_PROTO_AT;
    seq_at = (l3_kind == L3_IPV6) ? 7'(IPV6_LEN + ICMP_LEN - 8'd1)
                                  : 7'(IPV4_LEN + ICMP_LEN - 8'd1);
    etype_full = {outer_ethertype[15:8], beat.data};
    if (l3_kind != L3_NONE && byte_offset >= base_now) begin
      if (rel == proto_at) begin
        next_protocol_next = beat.data;
      end
      if (rel == seq_at) begin
        sequence_even_next = ~beat.data[0];
      end
    end else if (byte_offset == OFF_TYPE_HI) begin
      outer_ethertype_next = {beat.data, 8'd0};
    end else if (byte_offset == OFF_TYPE_LO) begin
      outer_ethertype_next = etype_full;
      if (etype_full == TYPE_8021Q || etype_full == TYPE_8021AD) begin
        vlan_tagged_next = 1'b1;
      end else begin
        l3_kind_next = kind_of(etype_full);
      end
    end else if (vlan_tagged && byte_offset == OFF_INNER_HI) begin
      outer_ethertype_next = {beat.data, 8'd0};
    end else if (vlan_tagged && byte_offset == OFF_INNER_LO) begin
      outer_ethertype_next = etype_full;
      l3_kind_next = kind_of(etype_full);
    end
  end

  always_comb begin
    len = {1'b0, byte_offset} + 8'd1;
    base = vlan_tagged_next ? (ETH_LEN + TAG_LEN) : ETH_LEN;
    hdr_end = base + ((l3_kind_next == L3_IPV6) ? IPV6_LEN : IPV4_LEN);
    proto = (l3_kind_next == L3_IPV6) ? PROTO_ICMPV6 : PROTO_ICMP;
    if (len < ETH_LEN) begin
      verdict = VERDICT_DROP;
    end else if (vlan_tagged_next && len < ETH_LEN + TAG_LEN) begin
      verdict = VERDICT_DROP;
    end else if (len < hdr_end) begin
      verdict = VERDICT_PASS;
    end else if (next_protocol_next != proto) begin
      verdict = VERDICT_PASS;
    end else if (len < hdr_end + ICMP_LEN) begin
      verdict = VERDICT_PASS;
    end else begin
      verdict = sequence_even_next ? VERDICT_DROP : VERDICT_PASS;
    end
  end

  always_comb begin
    if (beat.last) begin
      byte_offset_next = '0;
    end else if (byte_offset < OFF_MAX) begin
      byte_offset_next = byte_offset + 7'd1;
    end else begin
      byte_offset_next = byte_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      outer_ethertype <= '0;
      vlan_tagged <= 1'b0;
      l3_kind <= L3_NONE;
      next_protocol <= '0;
      sequence_even <= 1'b0;
    end else if (step) begin
      byte_offset <= byte_offset_next;
      if (beat.last) begin
        outer_ethertype <= '0;
        vlan_tagged <= 1'b0;
        l3_kind <= L3_NONE;
        next_protocol <= '0;
        sequence_even <= 1'b0;
      end else begin
        outer_ethertype <= outer_ethertype_next;
        vlan_tagged <= vlan_tagged_next;
        l3_kind <= l3_kind_next;
        next_protocol <= next_protocol_next;
        sequence_even <= sequence_even_next;
      end
    end
  end

endmodule

// ===== rtl/icmp_echo_parity_packet_filter.sv =====
// Top level of the ICMP echo parity packet filter: input register, parser and result register.
// Depends on iepf_pkg and iepf_parse.
//
//   Channel  Dir  Bus                    Beat
//   s_*      in   tdata[7:0], tlast      one frame byte, tlast on the final byte
//   m_*      out  tdata[7:0]             one verdict per frame, bit 0
//
// One byte is taken each cycle while no final byte is held; a byte passes the input register
// and then the parser, whose verdict on a final byte is loaded into the result register.
// Only a final byte waits for a free result register; other bytes are always consumed.
// Reset clears the frame state and both valid flags.
module icmp_echo_parity_packet_filter
  import iepf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] verdict, [7:1] zero
);

  iepf_beat_t in_beat;
  logic       in_valid;
  logic       out_free;
  logic       consume;
  verdict_t   verdict;
  verdict_t   out_verdict;

  assign out_free = ~m_tvalid | m_tready;
  assign consume = in_valid & (~in_beat.last | out_free);
  assign s_tready = ~in_valid | consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_beat <= '{data: s_tdata, last: s_tlast};
    end
  end

  iepf_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (consume),
    .beat    (in_beat),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && in_beat.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_beat.last) begin
      out_verdict <= verdict;
    end
  end

  assign m_tdata = {7'd0, out_verdict};

`ifndef NO_ASSERTIONS
  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(consume && in_beat.last))
    else $error("verdict raised without a final byte");

  a_last_needs_room: assert property (@(posedge clk) disable iff (rst)
    (consume && in_beat.last) |-> out_free)
    else $error("final byte taken while the result register was full");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with an empty input register");
`endif

endmodule
